// ===== src/ppim0_pkg.sv =====
// Shared types and constants for the mode 0 parallel port interface.
// No dependencies; used by ppim0_update, parallel_port_interface_mode0_core and the testbench.
package ppim0_pkg;

   localparam int unsigned NumPorts = 3;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   localparam logic [1:0] ADDR_PORT_A  = 2'd0;
   localparam logic [1:0] ADDR_PORT_B  = 2'd1;
   localparam logic [1:0] ADDR_PORT_C  = 2'd2;
   localparam logic [1:0] ADDR_CONTROL = 2'd3;

   localparam logic [7:0] CTRL_READ_VALUE = 8'hff;
   localparam logic [7:0] DIR_ALL_INPUT   = 8'hff;

   // control word bit positions
   localparam int unsigned CW_MODE_SET = 7;
   localparam int unsigned CW_DIR_A    = 4;
   localparam int unsigned CW_DIR_CHI  = 3;
   localparam int unsigned CW_GB_MODE  = 2;
   localparam int unsigned CW_DIR_B    = 1;
   localparam int unsigned CW_DIR_CLO  = 0;
   localparam int unsigned CW_BSR_VAL  = 0;

   typedef struct packed {
      logic [NumPorts-1:0][7:0] dir;     // 1 = input bit
      logic [NumPorts-1:0][7:0] latch;
      logic [NumPorts-1:0][7:0] drive;
      logic [NumPorts-1:0][7:0] change;
      logic [NumPorts-1:0]      flags;
      logic [1:0]               ga_mode;
      logic                     gb_mode;
   } ppi_state_type;

   typedef struct packed {
      logic       action;
      logic [1:0] address;
      logic [7:0] write_data;
      logic [7:0] pins_a_in;
      logic [7:0] pins_b_in;
      logic [7:0] pins_c_in;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] drive_a;
      logic [7:0] drive_b;
      logic [7:0] drive_c;
      logic [7:0] changed_a;
      logic [7:0] changed_b;
      logic [7:0] changed_c;
      logic [2:0] updated_mask;
   } rsp_beat_type;

   // drive bit is the latch where output, 1 where input
   function automatic logic [7:0] drive_of(input logic [7:0] latch, input logic [7:0] dir);
      drive_of = (latch & ~dir) | dir;
   endfunction

endpackage

// ===== src/ppim0_update.sv =====
// Single-access update: next port state and result beat for one bus access.
// Depends on ppim0_pkg.
module ppim0_update (
   input  ppim0_pkg::ppi_state_type cur,
   input  ppim0_pkg::req_beat_type  req,
   output ppim0_pkg::ppi_state_type nxt,
   output ppim0_pkg::rsp_beat_type  rsp
);

   logic [7:0] d;
   logic [7:0] dir_a_new;
   logic [7:0] dir_b_new;
   logic [7:0] dir_c_new;
   logic [7:0] bit_sel;
   logic [7:0] latch_c_new;
   logic [7:0] rd;

   assign d         = req.write_data;
   assign dir_a_new = {8{d[ppim0_pkg::CW_DIR_A]}};
   assign dir_b_new = {8{d[ppim0_pkg::CW_DIR_B]}};
   assign dir_c_new = {{4{d[ppim0_pkg::CW_DIR_CHI]}}, {4{d[ppim0_pkg::CW_DIR_CLO]}}};
   assign bit_sel   = 8'd1 << d[3:1];
   assign latch_c_new = d[ppim0_pkg::CW_BSR_VAL] ? (cur.latch[2] | bit_sel)
                                                 : (cur.latch[2] & ~bit_sel);

   always_comb begin
      nxt = cur;
      rd  = 8'd0;
      if (req.action == ppim0_pkg::ACT_WRITE) begin
         nxt.change = '0;
         nxt.flags  = '0;
         case (req.address)
            ppim0_pkg::ADDR_PORT_A, ppim0_pkg::ADDR_PORT_B, ppim0_pkg::ADDR_PORT_C: begin
               for (int p = 0; p < ppim0_pkg::NumPorts; p++) begin
                  if (req.address == 2'(p)) begin
                     nxt.latch[p]  = d;
                     nxt.drive[p]  = ppim0_pkg::drive_of(d, cur.dir[p]);
                     nxt.change[p] = cur.drive[p] ^ nxt.drive[p];
                     nxt.flags[p]  = 1'b1;
                  end
               end
            end
            ppim0_pkg::ADDR_CONTROL: begin
               if (d[ppim0_pkg::CW_MODE_SET]) begin
                  nxt.ga_mode = d[6:5];
                  nxt.gb_mode = d[ppim0_pkg::CW_GB_MODE];
                  if (d[6:5] == 2'd0 && !d[ppim0_pkg::CW_GB_MODE]) begin
                     nxt.dir[0] = dir_a_new;
                     nxt.dir[1] = dir_b_new;
                     nxt.dir[2] = dir_c_new;
                     // second refresh after clearing latches: drive = dir, and its
                     // change against the first refresh is old latch on output bits
                     nxt.latch  = '0;
                     nxt.drive  = {dir_c_new, dir_b_new, dir_a_new};
                     nxt.change[0] = cur.latch[0] & ~dir_a_new;
                     nxt.change[1] = cur.latch[1] & ~dir_b_new;
                     nxt.change[2] = cur.latch[2] & ~dir_c_new;
                     nxt.flags  = '1;
                  end
               end else begin
                  nxt.latch[2]  = latch_c_new;
                  nxt.drive[2]  = ppim0_pkg::drive_of(latch_c_new, cur.dir[2]);
                  nxt.change[2] = cur.drive[2] ^ nxt.drive[2];
                  nxt.flags[2]  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else begin
         case (req.address)
            ppim0_pkg::ADDR_PORT_A:
               rd = (cur.dir[0] == 8'd0) ? cur.latch[0] : req.pins_a_in;
            ppim0_pkg::ADDR_PORT_B:
               rd = (cur.dir[1] == 8'd0) ? cur.latch[1] : req.pins_b_in;
            ppim0_pkg::ADDR_PORT_C:
               rd = (cur.latch[2] & ~cur.dir[2]) | (req.pins_c_in & cur.dir[2]);
            default:
               rd = ppim0_pkg::CTRL_READ_VALUE;
         endcase
      end
   end

   always_comb begin
      rsp.read_data    = rd;
      rsp.drive_a      = nxt.drive[0];
      rsp.drive_b      = nxt.drive[1];
      rsp.drive_c      = nxt.drive[2];
      rsp.changed_a    = nxt.change[0];
      rsp.changed_b    = nxt.change[1];
      rsp.changed_c    = nxt.change[2];
      rsp.updated_mask = nxt.flags;
   end

endmodule

// ===== src/parallel_port_interface_mode0_core.sv =====
// Top level of the mode 0 parallel port interface: state registers and result buffering.
// Depends on ppim0_pkg and ppim0_update.
//
// Usage:
//   req_* carries one bus access per beat (read or write to port A, B, C or the
//   control word, plus the current pin levels). rsp_* returns one beat per access:
//   read data (zero on writes), the pin drive of all ports after the access, the
//   per-port changed masks and the updated flags of the last write.
//   The result beat is registered: it enters the result register, or the skid register
//   when the result register holds a beat not yet taken. Throughput is one access per cycle
//   while req_stall is low; the port state updates at acceptance, so the next access sees it immediately.
//   A two-entry output buffer (result register plus skid register) sits on the
//   result side; req_stall rises only when both are full, i.e. after the
//   receiver has held rsp_stall with a beat pending and another was accepted.
//   Reset (synchronous, active high) sets all ports to input, clears latches,
//   drive, changed masks, flags and group modes, and empties the buffer.
module parallel_port_interface_mode0_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [1:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_pins_a_in,
   input  logic [7:0] req_pins_b_in,
   input  logic [7:0] req_pins_c_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_drive_a,
   output logic [7:0] rsp_drive_b,
   output logic [7:0] rsp_drive_c,
   output logic [7:0] rsp_changed_a,
   output logic [7:0] rsp_changed_b,
   output logic [7:0] rsp_changed_c,
   output logic [2:0] rsp_updated_mask
);

   ppim0_pkg::ppi_state_type state_ff, state_in;
   ppim0_pkg::req_beat_type  req_beat;
   ppim0_pkg::rsp_beat_type  rsp_new;
   ppim0_pkg::rsp_beat_type  out_ff, out_in;
   ppim0_pkg::rsp_beat_type  skid_ff, skid_in;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic req_take;
   logic rsp_take;

   assign req_beat = '{action:     req_action,
                       address:    req_address,
                       write_data: req_write_data,
                       pins_a_in:  req_pins_a_in,
                       pins_b_in:  req_pins_b_in,
                       pins_c_in:  req_pins_c_in};

   ppim0_update u_update (
      .cur (state_ff),
      .req (req_beat),
      .nxt (state_in),
      .rsp (rsp_new)
   );

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = rsp_new;
            out_valid_in = req_take;
         end
      end else if (req_take) begin
         skid_in       = rsp_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.dir    <= {ppim0_pkg::NumPorts{ppim0_pkg::DIR_ALL_INPUT}};
         state_ff.latch  <= '0;
         state_ff.drive  <= '0;
         state_ff.change <= '0;
         state_ff.flags  <= '0;
         state_ff.ga_mode <= '0;
         state_ff.gb_mode <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_ff.read_data;
   assign rsp_drive_a      = out_ff.drive_a;
   assign rsp_drive_b      = out_ff.drive_b;
   assign rsp_drive_c      = out_ff.drive_c;
   assign rsp_changed_a    = out_ff.changed_a;
   assign rsp_changed_b    = out_ff.changed_b;
   assign rsp_changed_c    = out_ff.changed_c;
   assign rsp_updated_mask = out_ff.updated_mask;

`ifndef SYNTH
   // skid entry only fills behind a pending result
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register valid while result register empty");

   // a port can only report changed bits if it was refreshed
   a_change_needs_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_changed_a != 8'd0 || rsp_changed_b != 8'd0 || rsp_changed_c != 8'd0)
      |-> ((rsp_changed_a == 8'd0 || rsp_updated_mask[0]) &&
           (rsp_changed_b == 8'd0 || rsp_updated_mask[1]) &&
           (rsp_changed_c == 8'd0 || rsp_updated_mask[2])))
      else $error("changed mask reported for a port not refreshed");

   // reads never disturb port state
   a_read_keeps_state : assert property (@(posedge clock) disable iff (reset)
      req_take && req_action == ppim0_pkg::ACT_READ |=> $stable(state_ff))
      else $error("read access modified port state");
`endif

endmodule

// ===== verif/tb_parallel_port_interface_mode0_core.sv =====
// Self-checking testbench for parallel_port_interface_mode0_core: a directed table and then
// random bus accesses, each result beat compared field by field with its known table row or an in-bench port model.
// Depends on ppim0_pkg and the core RTL only.
module tb_parallel_port_interface_mode0_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned GaModeLsb   = 5;     // group A mode field, control word bits 6:5
   localparam int          RandomItems = 1125;
   localparam int          PressureAt  = 350;   // result count where the long hold-off starts
   localparam int          PressureLen = 40;

   typedef struct {
      ppim0_pkg::req_beat_type acc;
      bit                      known;
      ppim0_pkg::rsp_beat_type want;
   } vector_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_action = ppim0_pkg::ACT_READ;
   logic [1:0] req_address = ppim0_pkg::ADDR_PORT_A;
   logic [7:0] req_write_data = 8'h00;
   logic [7:0] req_pins_a_in = 8'h00;
   logic [7:0] req_pins_b_in = 8'h00;
   logic [7:0] req_pins_c_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic [7:0] rsp_drive_a;
   logic [7:0] rsp_drive_b;
   logic [7:0] rsp_drive_c;
   logic [7:0] rsp_changed_a;
   logic [7:0] rsp_changed_b;
   logic [7:0] rsp_changed_c;
   logic [2:0] rsp_updated_mask;

   parallel_port_interface_mode0_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_pins_a_in    (req_pins_a_in),
      .req_pins_b_in    (req_pins_b_in),
      .req_pins_c_in    (req_pins_c_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_drive_a      (rsp_drive_a),
      .rsp_drive_b      (rsp_drive_b),
      .rsp_drive_c      (rsp_drive_c),
      .rsp_changed_a    (rsp_changed_a),
      .rsp_changed_b    (rsp_changed_b),
      .rsp_changed_c    (rsp_changed_c),
      .rsp_updated_mask (rsp_updated_mask)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // port model state
   logic [7:0]   port_dir [3];     // 1 = input bit
   logic [7:0]   port_latch [3];
   logic [7:0]   port_drive [3];
   logic [7:0]   port_changed [3];
   logic [2:0]   port_fresh;
   logic [1:0]   group_a_mode;
   logic         group_b_mode;

   ppim0_pkg::rsp_beat_type expected_rsp [$];
   int           mismatches = 0;
   int           accesses_sent = 0;
   int           reads_sent = 0;
   int           port_writes = 0;
   int           mode_set_words = 0;
   int           bit_set_words = 0;
   int           beats_checked = 0;
   int           rsp_taken = 0;
   int           stall_run = 0;
   int           stall_peak = 0;

   task automatic report_mismatch(input string field, input int beat, input int got,
                                  input int want);
      if (mismatches < 40)
         $display("MISMATCH %s at beat %0d: got %0h want %0h", field, beat, got, want);
      mismatches++;
   endtask

   task automatic refresh_port(input int p);
      logic [7:0] nd;
      nd = (port_latch[p] & ~port_dir[p]) | port_dir[p];
      port_changed[p] = port_drive[p] ^ nd;
      port_drive[p] = nd;
      port_fresh[p] = 1'b1;
   endtask

   task automatic predict_access(input ppim0_pkg::req_beat_type a,
                                 output ppim0_pkg::rsp_beat_type r);
      logic [7:0] d;
      d = a.write_data;
      r = '0;
      if (a.action == ppim0_pkg::ACT_WRITE) begin
         for (int p = 0; p < 3; p++) port_changed[p] = 8'h00;
         port_fresh = 3'b000;
         if (a.address == ppim0_pkg::ADDR_CONTROL) begin
            if (d[ppim0_pkg::CW_MODE_SET]) begin
               group_a_mode = d[GaModeLsb +: 2];
               group_b_mode = d[ppim0_pkg::CW_GB_MODE];
               if (group_a_mode == 2'b00 && group_b_mode == 1'b0) begin
                  port_dir[0] = {8{d[ppim0_pkg::CW_DIR_A]}};
                  port_dir[1] = {8{d[ppim0_pkg::CW_DIR_B]}};
                  port_dir[2] = {{4{d[ppim0_pkg::CW_DIR_CHI]}}, {4{d[ppim0_pkg::CW_DIR_CLO]}}};
                  // refresh, clear latches, refresh again: masks show the second pass
                  for (int p = 0; p < 3; p++) refresh_port(p);
                  for (int p = 0; p < 3; p++) port_latch[p] = 8'h00;
                  for (int p = 0; p < 3; p++) refresh_port(p);
               end
            end else begin
               port_latch[2][d[3:1]] = d[ppim0_pkg::CW_BSR_VAL];
               refresh_port(2);
            end
         end else begin
            port_latch[a.address] = d;
            refresh_port(int'(a.address));
         end
      end else begin
         case (a.address)
            ppim0_pkg::ADDR_PORT_A:
               r.read_data = (port_dir[0] == 8'h00) ? port_latch[0] : a.pins_a_in;
            ppim0_pkg::ADDR_PORT_B:
               r.read_data = (port_dir[1] == 8'h00) ? port_latch[1] : a.pins_b_in;
            ppim0_pkg::ADDR_PORT_C:
               r.read_data = (port_latch[2] & ~port_dir[2]) | (a.pins_c_in & port_dir[2]);
            default:
               r.read_data = ppim0_pkg::CTRL_READ_VALUE;
         endcase
      end
      r.drive_a      = port_drive[0];
      r.drive_b      = port_drive[1];
      r.drive_c      = port_drive[2];
      r.changed_a    = port_changed[0];
      r.changed_b    = port_changed[1];
      r.changed_c    = port_changed[2];
      r.updated_mask = port_fresh;
   endtask

   function automatic vector_row_type vec(input logic act, input logic [1:0] adr,
                                          input logic [7:0] d, input logic [7:0] pa,
                                          input logic [7:0] pb, input logic [7:0] pc,
                                          input bit known = 1'b0,
                                          input ppim0_pkg::rsp_beat_type want = '0);
      vector_row_type v;
      v.acc   = '{act, adr, d, pa, pb, pc};
      v.known = known;
      v.want  = want;
      return v;
   endfunction

   function automatic logic [7:0] pin_levels();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hff;
      return 8'($urandom);
   endfunction

   function automatic ppim0_pkg::req_beat_type random_access();
      ppim0_pkg::req_beat_type a;
      int pick;
      a.action     = 1'($urandom_range(0, 1));
      a.address    = 2'($urandom_range(0, 3));
      a.write_data = 8'($urandom);
      // steer control writes toward words that do something
      if (a.action == ppim0_pkg::ACT_WRITE && a.address == ppim0_pkg::ADDR_CONTROL) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            a.write_data[ppim0_pkg::CW_MODE_SET] = 1'b0;
         end else if (pick < 85) begin
            a.write_data[ppim0_pkg::CW_MODE_SET] = 1'b1;
            a.write_data[GaModeLsb +: 2] = 2'b00;
            a.write_data[ppim0_pkg::CW_GB_MODE] = 1'b0;
         end else begin
            a.write_data[ppim0_pkg::CW_MODE_SET] = 1'b1;
         end
      end
      a.pins_a_in = pin_levels();
      a.pins_b_in = pin_levels();
      a.pins_c_in = pin_levels();
      return a;
   endfunction

   task automatic offer(input ppim0_pkg::req_beat_type a, input bit known,
                        input ppim0_pkg::rsp_beat_type want);
      ppim0_pkg::rsp_beat_type model_rsp;
      int gap;
      gap = (accesses_sent % 300 >= 200) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= a.action;
      req_address    <= a.address;
      req_write_data <= a.write_data;
      req_pins_a_in  <= a.pins_a_in;
      req_pins_b_in  <= a.pins_b_in;
      req_pins_c_in  <= a.pins_c_in;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_access(a, model_rsp);
      expected_rsp.push_back(known ? want : model_rsp);
      accesses_sent++;
      if (a.action == ppim0_pkg::ACT_READ) reads_sent++;
      else if (a.address != ppim0_pkg::ADDR_CONTROL) port_writes++;
      else if (a.write_data[ppim0_pkg::CW_MODE_SET]) mode_set_words++;
      else bit_set_words++;
   endtask

   // result checker
   always @(posedge clock) begin
      ppim0_pkg::rsp_beat_type want;
      if (!reset && req_valid && req_stall === 1'b1) begin
         stall_run++;
         if (stall_run > stall_peak) stall_peak = stall_run;
      end else begin
         stall_run = 0;
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected beat", beats_checked, int'(rsp_read_data), 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", beats_checked, int'(rsp_read_data),
                               int'(want.read_data));
            if (rsp_drive_a !== want.drive_a)
               report_mismatch("drive_a", beats_checked, int'(rsp_drive_a),
                               int'(want.drive_a));
            if (rsp_drive_b !== want.drive_b)
               report_mismatch("drive_b", beats_checked, int'(rsp_drive_b),
                               int'(want.drive_b));
            if (rsp_drive_c !== want.drive_c)
               report_mismatch("drive_c", beats_checked, int'(rsp_drive_c),
                               int'(want.drive_c));
            if (rsp_changed_a !== want.changed_a)
               report_mismatch("changed_a", beats_checked, int'(rsp_changed_a),
                               int'(want.changed_a));
            if (rsp_changed_b !== want.changed_b)
               report_mismatch("changed_b", beats_checked, int'(rsp_changed_b),
                               int'(want.changed_b));
            if (rsp_changed_c !== want.changed_c)
               report_mismatch("changed_c", beats_checked, int'(rsp_changed_c),
                               int'(want.changed_c));
            if (rsp_updated_mask !== want.updated_mask)
               report_mismatch("updated_mask", beats_checked, int'(rsp_updated_mask),
                               int'(want.updated_mask));
         end
         beats_checked++;
      end
   end

   // receiver: random hold-off per beat outside the no-hold windows, one long hold to back up the input side
   initial begin
      int hold;
      forever begin
         if (rsp_taken == PressureAt) hold = PressureLen;
         else if (rsp_taken % 300 >= 200) hold = 0;
         else hold = $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         rsp_taken++;
      end
   end

   initial begin
      #500_000;
      $display("tb_parallel_port_interface_mode0_core NOT OK");
      $finish;
   end

   initial begin
      vector_row_type directed_vectors [$];
      group_a_mode = 2'b00;
      group_b_mode = 1'b0;
      port_fresh   = 3'b000;
      for (int p = 0; p < 3; p++) begin
         port_dir[p]     = ppim0_pkg::DIR_ALL_INPUT;
         port_latch[p]   = 8'h00;
         port_drive[p]   = 8'h00;
         port_changed[p] = 8'h00;
      end

      // known rows: fields are read_data, drive a/b/c, changed a/b/c, updated_mask
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_CONTROL,
         8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'b000}));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_PORT_A,
         8'hff, 8'h5a, 8'hff, 8'hff, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'h5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'b000}));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_PORT_C,
         8'h00, 8'h00, 8'h00, 8'ha5, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'ha5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'b000}));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_PORT_B,
         8'h00, 8'hff, 8'h00, 8'hff, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'b000}));
      // write to an input port: drive goes to all ones
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_PORT_A,
         8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 3'b001}));
      // all outputs: only the second refresh shows in the change masks
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h80, 8'h00, 8'h00, 8'h00, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'b111}));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_PORT_A,
         8'hff, 8'h00, 8'h00, 8'h00, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 3'b001}));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_PORT_A,
         8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
         ppim0_pkg::rsp_beat_type'{8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 3'b001}));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_PORT_B,
         8'ha5, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_PORT_C,
         8'h3c, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_PORT_C,
         8'h00, 8'hff, 8'hff, 8'hff));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h0f, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h04, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h71, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_CONTROL,
         8'hff, 8'h00, 8'h00, 8'h00));
      // nonzero group modes: stored, port directions and latches kept
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'he0, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_PORT_A,
         8'h12, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'hff, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h84, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h9b, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_PORT_B,
         8'h00, 8'ha5, 8'h3c, 8'hff));
      // mixed port C halves
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h88, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_PORT_C,
         8'hff, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_READ, ppim0_pkg::ADDR_PORT_C,
         8'h00, 8'h00, 8'h00, 8'h00));
      directed_vectors.push_back(vec(ppim0_pkg::ACT_WRITE, ppim0_pkg::ADDR_CONTROL,
         8'h81, 8'h00, 8'h00, 8'h00));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_vectors[i])
         offer(directed_vectors[i].acc, directed_vectors[i].known, directed_vectors[i].want);
      repeat (RandomItems) offer(random_access(), 1'b0, '0);
      req_valid <= 1'b0;

      for (int i = 0; i < 2000 && expected_rsp.size() != 0; i++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("missing beats", beats_checked, expected_rsp.size(), 0);

      $display("covered %0d accesses: %0d reads, %0d port writes, %0d mode-set, %0d bit set/reset",
               accesses_sent, reads_sent, port_writes, mode_set_words, bit_set_words);
      $display("%0d result beats checked, longest input stall %0d cycles, %0d mismatches",
               beats_checked, stall_peak, mismatches);
      if (mismatches == 0)
         $display("tb_parallel_port_interface_mode0_core OK");
      else
         $display("tb_parallel_port_interface_mode0_core NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ppim0_pkg.sv
src/ppim0_update.sv
src/parallel_port_interface_mode0_core.sv
verif/tb_parallel_port_interface_mode0_core.sv
